// ===== rtl/ash_pkg.sv =====
// Shared types and constants for the dictionary automaton hash lookup.
package ash_pkg;

  localparam int LABEL_W         = 8;
  localparam int INDEX_W         = 16;
  localparam int NEXT_W          = 17;
  localparam int BASE_W          = 16;
  localparam int HASH_W          = 24;
  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_DEPTH       = 4;
  localparam int RCNT_W          = $clog2(RES_DEPTH + 1);

  localparam logic [NEXT_W-1:0] NEXT_FINAL = {NEXT_W{1'b1}};
  localparam logic [HASH_W-1:0] HASH_MAX   = {HASH_W{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_KEY   = 1'b1
  } op_t;

  typedef struct packed {
    logic [HASH_W-1:0]  inc;
    logic [NEXT_W-1:0]  nxt;
    logic [LABEL_W-1:0] label;
  } slot_t;

  typedef struct packed {
    op_t                op;
    logic               wr_ok;
    logic [INDEX_W-1:0] index;
    slot_t              slot;
    logic [LABEL_W-1:0] kbyte;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               exact_found;
    logic [HASH_W-1:0]  exact_hash;
    logic [LABEL_W-1:0] exact_count;
    logic               prefix_found;
    logic [HASH_W-1:0]  prefix_hash;
    logic [LABEL_W-1:0] prefix_count;
  } res_t;

endpackage

// ===== rtl/ash_if.sv =====
// Valid/ready channel interfaces for table writes, key bytes and lookup results.
interface ash_in_if import ash_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [INDEX_W-1:0]        entry_index;
  logic [LABEL_W-1:0]        entry_label;
  logic signed [NEXT_W-1:0]  entry_next;
  logic [HASH_W-1:0]         entry_increment;
  logic [LABEL_W-1:0]        key_byte;
  logic                      key_last;

  modport source (
    output valid, command, entry_index, entry_label, entry_next, entry_increment,
           key_byte, key_last,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_label, entry_next, entry_increment,
           key_byte, key_last,
    output ready
  );
endinterface

interface ash_out_if import ash_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               exact_found;
  logic [HASH_W-1:0]  exact_hash;
  logic [LABEL_W-1:0] exact_count;
  logic               prefix_found;
  logic [HASH_W-1:0]  prefix_hash;
  logic [LABEL_W-1:0] prefix_count;

  modport source (
    output valid, exact_found, exact_hash, exact_count, prefix_found, prefix_hash,
           prefix_count,
    input  ready
  );
  modport sink (
    input  valid, exact_found, exact_hash, exact_count, prefix_found, prefix_hash,
           prefix_count,
    output ready
  );
endinterface

// ===== rtl/automaton_string_to_hash.sv =====
// Dictionary automaton lookup: table loading, byte-per-cycle key walk, hash results.
// The block takes one item per clock: a table write or one key byte. Each key byte costs
// one transition read of the table plus one read of slot 0 of the state it reaches, on
// the two read ports of the table memory; the next byte's slot address is formed from
// the previous byte's registered read data plus the byte, which lets bytes follow each
// other in consecutive cycles. Each result passes through the s2 and s3 walk stages into
// a result buffer that holds up to four results while the output is stalled; only when
// that buffer is committed does a last byte wait in the input queue. The table is
// not cleared at reset, so every slot that a walk reaches must have been written first.
module automaton_string_to_hash import ash_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ash_in_if.sink    in_ch,
  ash_out_if.source out_ch
);

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic [RCNT_W-1:0] res_free;
  logic              res_push;
  res_t              res_data;

  ash_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  ash_walk #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_free (res_free),
    .res_push (res_push),
    .res_data (res_data)
  );

  ash_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_free (res_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/ash_front.sv =====
// Input front end: accepts and classifies items into a short queue.
module ash_front import ash_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  ash_in_if.sink in_ch,
  output logic   q_valid,
  output item_t  q_item,
  input  logic   q_pop
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  item_t             buf_r [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r;
  logic [QP_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  item_t             item_nxt;

  assign in_ch.ready = (count_r < QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_item      = buf_r[rd_ptr_r];

  always_comb begin
    item_nxt.op         = op_t'(in_ch.command);
    item_nxt.wr_ok      = (32'(in_ch.entry_index) < TABLE_DEPTH);
    item_nxt.index      = in_ch.entry_index;
    item_nxt.slot.inc   = in_ch.entry_increment;
    item_nxt.slot.nxt   = $unsigned(in_ch.entry_next);
    item_nxt.slot.label = in_ch.entry_label;
    item_nxt.kbyte      = in_ch.key_byte;
    item_nxt.last       = in_ch.key_last;
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= QP_W'(wr_ptr_r + 1'b1);
      end
      if (q_pop) begin
        rd_ptr_r <= QP_W'(rd_ptr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= item_nxt;
    end
  end

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("queue popped while empty");

endmodule

// ===== rtl/ash_walk.sv =====
// Back end: transition table, byte-per-cycle walk pipeline and prefix tracking.
module ash_walk import ash_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [RCNT_W-1:0] res_free,
  output logic              res_push,
  output res_t              res_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  slot_t               table_mem_r [TABLE_DEPTH];
  slot_t               rd_a_r;
  slot_t               rd_b_r;

  logic [BASE_W-1:0]   base_r;
  logic [HASH_W-1:0]   hash_r;
  logic                failed_r;
  logic                best_valid_r;
  logic [HASH_W-1:0]   best_hash_r;
  logic [LABEL_W-1:0]  best_count_r;

  logic                s2_vld_r;
  logic                s2_last_r;
  logic [LABEL_W-1:0]  s2_byte_r;
  logic                s2_inr_r;
  logic                s3_vld_r;
  logic                s3_last_r;
  logic                s3_step_r;
  logic [HASH_W-1:0]   s3_hash_r;
  logic                s3_inr_r;

  logic [RCNT_W-1:0]   pending;
  logic                is_last_key;
  logic                step_ok;
  logic [HASH_W:0]     hash_sum;
  logic [HASH_W-1:0]   hash_nxt;
  logic [BASE_W-1:0]   new_base;
  logic [BASE_W-1:0]   eff_base;
  logic [BASE_W:0]     addr_a;
  logic                inr_a;
  logic                inr_b;
  logic                best_upd;
  logic                exact;

  assign pending     = RCNT_W'(s2_vld_r && s2_last_r) + RCNT_W'(s3_vld_r && s3_last_r);
  assign is_last_key = (q_item.op == OP_KEY) && q_item.last;
  assign q_pop       = q_valid && (!is_last_key || (pending < res_free));

  assign new_base = rd_a_r.nxt[BASE_W-1:0];
  assign step_ok  = s2_vld_r && !failed_r && (s2_byte_r != '0) && s2_inr_r &&
                    (rd_a_r.label == s2_byte_r) && (rd_a_r.nxt != '0) &&
                    !rd_a_r.nxt[NEXT_W-1];
  assign hash_sum = {1'b0, hash_r} + {1'b0, rd_a_r.inc};
  assign hash_nxt = hash_sum[HASH_W] ? HASH_MAX : hash_sum[HASH_W-1:0];

  always_comb begin
    eff_base = base_r;
    if (s2_vld_r) begin
      if (s2_last_r) begin
        eff_base = '0;
      end else if (step_ok) begin
        eff_base = new_base;
      end
    end
  end

  assign addr_a = {1'b0, eff_base} + (BASE_W + 1)'(q_item.kbyte);
  assign inr_a  = (32'(addr_a) < TABLE_DEPTH);
  assign inr_b  = (32'(new_base) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (q_pop && (q_item.op == OP_WRITE) && q_item.wr_ok) begin
      table_mem_r[AW'(q_item.index)] <= q_item.slot;
    end
    rd_a_r <= table_mem_r[AW'(addr_a)];
    rd_b_r <= table_mem_r[AW'(new_base)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= q_pop && (q_item.op == OP_KEY);
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r <= q_item.last;
    s2_byte_r <= q_item.kbyte;
    s2_inr_r  <= inr_a;
    s3_last_r <= s2_last_r;
    s3_step_r <= step_ok;
    s3_hash_r <= hash_nxt;
    s3_inr_r  <= inr_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      hash_r   <= '0;
      failed_r <= 1'b0;
    end else if (s2_vld_r) begin
      if (s2_last_r) begin
        base_r   <= '0;
        hash_r   <= '0;
        failed_r <= 1'b0;
      end else if (step_ok) begin
        base_r <= new_base;
        hash_r <= hash_nxt;
      end else begin
        failed_r <= 1'b1;
      end
    end
  end

  assign best_upd = s3_vld_r && s3_step_r && s3_inr_r && (rd_b_r.label != '0);
  assign exact    = s3_step_r && s3_inr_r && (rd_b_r.nxt == NEXT_FINAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_hash_r  <= '0;
      best_count_r <= '0;
    end else if (s3_vld_r) begin
      if (s3_last_r) begin
        best_valid_r <= 1'b0;
        best_hash_r  <= '0;
        best_count_r <= '0;
      end else if (best_upd) begin
        best_valid_r <= 1'b1;
        best_hash_r  <= s3_hash_r;
        best_count_r <= rd_b_r.label;
      end
    end
  end

  assign res_push = s3_vld_r && s3_last_r;

  always_comb begin
    res_data.exact_found  = exact;
    res_data.exact_hash   = exact ? s3_hash_r : '0;
    res_data.exact_count  = exact ? rd_b_r.label : '0;
    res_data.prefix_found = best_upd || best_valid_r;
    res_data.prefix_hash  = best_upd ? s3_hash_r : best_hash_r;
    res_data.prefix_count = best_upd ? rd_b_r.label : best_count_r;
  end

  a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_last_r) |=> ((base_r == '0) && (hash_r == '0) && !failed_r))
    else $error("walk state not restarted after last byte");

  a_best_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && s3_last_r) |=> !best_valid_r)
    else $error("best prefix not cleared after result");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_free != '0))
    else $error("result pushed without buffer room");

endmodule

// ===== rtl/ash_res_fifo.sv =====
// Result buffer that decouples the walk pipeline from the output channel.
module ash_res_fifo import ash_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_push,
  input  res_t              res_data,
  output logic [RCNT_W-1:0] res_free,
  ash_out_if.source         out_ch
);

  localparam int RP_W = $clog2(RES_DEPTH);

  res_t              buf_r [RES_DEPTH];
  logic [RP_W-1:0]   wr_ptr_r;
  logic [RP_W-1:0]   rd_ptr_r;
  logic [RCNT_W-1:0] count_r;
  logic [RCNT_W-1:0] count_nxt;
  logic              pop;
  res_t              head;

  assign res_free     = RCNT_W'(RES_DEPTH) - count_r;
  assign out_ch.valid = (count_r != '0);
  assign pop          = out_ch.valid && out_ch.ready;
  assign head         = buf_r[rd_ptr_r];

  assign out_ch.exact_found  = head.exact_found;
  assign out_ch.exact_hash   = head.exact_hash;
  assign out_ch.exact_count  = head.exact_count;
  assign out_ch.prefix_found = head.prefix_found;
  assign out_ch.prefix_hash  = head.prefix_hash;
  assign out_ch.prefix_count = head.prefix_count;

  always_comb begin
    count_nxt = count_r;
    if (res_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!res_push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (res_push) begin
        wr_ptr_r <= RP_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= RP_W'(rd_ptr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      buf_r[wr_ptr_r] <= res_data;
    end
  end

endmodule
